// ----- design/bti_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bti_pkg: shared types and constants of the breakpoint table interpolator
// Table depths, mode codes and the lerp request/response structs.
// ----------------------------------------------------------------------------
package bti_pkg;

    localparam int X_POINTS = 16;
    localparam int Y_POINTS = 16;
    localparam int XW = $clog2(X_POINTS);
    localparam int YW = $clog2(Y_POINTS);
    localparam int GW = XW + YW;

    typedef enum logic [2:0] {
        MODE_LOAD_X    = 3'd0,
        MODE_LOAD_Y    = 3'd1,
        MODE_LOAD_CRV  = 3'd2,
        MODE_LOAD_GRID = 3'd3,
        MODE_CURVE     = 3'd4,
        MODE_SURFACE   = 3'd5,
        MODE_NOP6      = 3'd6,
        MODE_NOP7      = 3'd7
    } mode_t;

    localparam logic CFG_X_POINTS = 1'b0;
    localparam logic CFG_Y_POINTS = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_XSRCH,
        ST_YSRCH,
        ST_CHECK,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_RD4,
        ST_L0,
        ST_L0W,
        ST_L1,
        ST_L1W,
        ST_L2,
        ST_L2W,
        ST_OUT
    } state_t;

    // one interpolation step: v0 + (v1-v0)*(p-p0)/(p1-p0)
    typedef struct packed {
        logic               start;
        logic signed [31:0] v0;
        logic signed [31:0] v1;
        logic signed [31:0] p0;
        logic signed [31:0] p1;
        logic signed [31:0] p;
    } lerp_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] value;
    } lerp_rsp_t;

endpackage

`default_nettype wire

// ----- design/bti_lerp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bti_lerp: serial interpolation step
// Magnitude product in L_MUL0/1, then restoring divide one bit a cycle.
// ----------------------------------------------------------------------------
module bti_lerp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire bti_pkg::lerp_req_t req,
    output bti_pkg::lerp_rsp_t      rsp
);
    import bti_pkg::*;

    typedef enum logic [2:0] {L_IDLE, L_MUL0, L_MUL1, L_DIV, L_DONE} lstate_t;

    lstate_t            st_reg, st_next;
    logic signed [31:0] v0_reg;
    logic               neg_reg;
    logic [32:0]        mag_reg;   // |v1-v0|
    logic [32:0]        d_reg;     // p-p0
    logic [32:0]        w_reg;     // p1-p0
    logic [65:0]        num_reg;   // product, shifts into quotient
    logic [33:0]        rem_reg;
    logic [6:0]         cnt_reg;
    logic               byp_reg;

    logic signed [32:0] dv, dd, ww;
    logic [33:0]        trial;
    logic [65:0]        pp;

    assign dv = {req.v1[31], req.v1} - {req.v0[31], req.v0};
    assign dd = {req.p[31], req.p} - {req.p0[31], req.p0};
    assign ww = {req.p1[31], req.p1} - {req.p0[31], req.p0};

    assign trial = {rem_reg[32:0], num_reg[65]} - {1'b0, w_reg};
    // mag*d[16:0] in L_MUL0, then mag*d[32:17] shifted and added in L_MUL1
    assign pp = (st_reg == L_MUL0) ? 66'(mag_reg * d_reg[16:0])
                                   : 66'(mag_reg * d_reg[32:17]) << 17;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            L_IDLE: if (req.start) st_next = L_MUL0;
            L_MUL0: st_next = byp_reg ? L_DONE : L_MUL1;
            L_MUL1: st_next = L_DIV;
            L_DIV:  if (cnt_reg == 7'd65) st_next = L_DONE;
            L_DONE: st_next = L_IDLE;
            default: st_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= L_IDLE;
        else st_reg <= st_next;
    end

    always_ff @(posedge aclk) begin
        unique case (st_reg)
            L_IDLE: if (req.start) begin
                v0_reg  <= req.v0;
                neg_reg <= dv[32];
                mag_reg <= dv[32] ? 33'(-dv) : 33'(dv);
                d_reg   <= 33'(dd);
                w_reg   <= 33'(ww);
                byp_reg <= (ww <= 0) || dd[32];
            end
            L_MUL0: begin
                num_reg <= pp;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            L_MUL1: num_reg <= num_reg + pp;
            L_DIV: begin
                if (!trial[33]) begin
                    rem_reg <= trial;
                    num_reg <= {num_reg[64:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[32:0], num_reg[65]};
                    num_reg <= {num_reg[64:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 7'd1;
            end
            default: ;
        endcase
    end

    // with p <= p1 the quotient stays within |v1-v0|; low 32 bits suffice
    always_comb begin
        rsp.done  = (st_reg == L_DONE);
        if (byp_reg) rsp.value = v0_reg;
        else if (neg_reg) rsp.value = v0_reg - num_reg[31:0];
        else rsp.value = v0_reg + num_reg[31:0];
    end

endmodule

`default_nettype wire

// ----- design/breakpoint_table_interpolator_core.sv -----
`default_nettype none
// Loads and unused modes go straight to the output register; curve and surface queries
//   search their axes one entry a cycle, then run one or three interpolation steps (none
//   for a first curve hit or a miss), each with a bit-serial divide. One transaction at
//   a time; the next is taken the cycle after the result moves to the output register.
// Reset: control and point counts (to 16) reset; table memories undefined until loaded.
// ----------------------------------------------------------------------------
// breakpoint_table_interpolator_core: curve and bilinear surface table lookup
// Tables sit in synchronous memories; a sequencer searches and interpolates.
// ----------------------------------------------------------------------------
module breakpoint_table_interpolator_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: mode[2:0] column[6:3] row[10:7] load_value[42:11]
    //        query_x[74:43] query_y[106:75], zero pad to 112
    input  wire logic [111:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: interpolated[31:0] status[32], zero pad to 40
    output logic [39:0]       m_tdata,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [4:0]   cfg_wdata
);
    import bti_pkg::*;

    // Memories (one read port each, registered read)
    logic signed [31:0] xbp_mem [X_POINTS];
    logic signed [31:0] ybp_mem [Y_POINTS];
    logic signed [31:0] crv_mem [X_POINTS];
    logic signed [31:0] grid_mem[X_POINTS*Y_POINTS];
    logic signed [31:0] xbp_rd, ybp_rd, crv_rd, grid_rd;
    logic [XW-1:0] xa;
    logic [YW-1:0] ya;
    logic [XW-1:0] ca;
    logic [GW-1:0] ga;

    logic [4:0] xcnt_reg, ycnt_reg;
    logic [4:0] nx, ny;

    state_t st_reg, st_next;
    logic [2:0]  mode_reg;
    logic signed [31:0] qx_reg, qy_reg;
    logic [4:0]  idx_reg, idx_next;   // search index, can reach count + 1
    logic [4:0]  j_reg, i_reg;
    logic        first_reg;           // exact first hit on x
    logic signed [31:0] xa_reg, xb_reg, ya_reg, yb_reg;
    logic signed [31:0] a_reg, b_reg, c_reg, d_reg, m0_reg, m1_reg;
    logic signed [31:0] res_reg;
    logic        stat_reg, ovalid_reg;
    logic signed [31:0] ores_reg;     // output register, frees the sequencer
    logic        ostat_reg;

    lerp_req_t lreq;
    lerp_rsp_t lrsp;

    bti_lerp u_lerp (.aclk(aclk), .aresetn(aresetn), .req(lreq), .rsp(lrsp));

    // effective counts clamp to [2, depth]
    assign nx = (xcnt_reg < 5'd2) ? 5'd2 : (xcnt_reg > 5'(X_POINTS)) ? 5'(X_POINTS) : xcnt_reg;
    assign ny = (ycnt_reg < 5'd2) ? 5'd2 : (ycnt_reg > 5'(Y_POINTS)) ? 5'(Y_POINTS) : ycnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xcnt_reg <= 5'd16;
            ycnt_reg <= 5'd16;
        end else if (cfg_we) begin
            if (cfg_index == CFG_X_POINTS) xcnt_reg <= cfg_wdata;
            else ycnt_reg <= cfg_wdata;
        end
    end

    assign s_tready = (st_reg == ST_IDLE);
    wire accept = s_tvalid && s_tready;
    // finished transaction moves to the output register once it is free
    wire out_load = (st_reg == ST_OUT) && (!ovalid_reg || m_tready);

    // Memory writes come straight from the input transaction
    wire [2:0] in_mode = s_tdata[2:0];
    wire [3:0] in_col  = s_tdata[6:3];
    wire [3:0] in_row  = s_tdata[10:7];
    wire [31:0] in_lv  = s_tdata[42:11];

    always_ff @(posedge aclk) begin
        if (accept) begin
            unique case (mode_t'(in_mode))
                MODE_LOAD_X:    xbp_mem[in_col] <= in_lv;
                MODE_LOAD_Y:    ybp_mem[in_row] <= in_lv;
                MODE_LOAD_CRV:  crv_mem[in_col] <= in_lv;
                MODE_LOAD_GRID: grid_mem[{in_row, in_col}] <= in_lv;
                default: ;
            endcase
        end
        xbp_rd  <= xbp_mem[xa];
        ybp_rd  <= ybp_mem[ya];
        crv_rd  <= crv_mem[ca];
        grid_rd <= grid_mem[ga];
    end

    // read addresses chosen by state
    always_comb begin
        xa = idx_reg[XW-1:0];
        ya = idx_reg[YW-1:0];
        ca = j_reg[XW-1:0];
        ga = {i_reg[YW-1:0], j_reg[XW-1:0]};
        unique case (st_reg)
            ST_RD0: begin xa = j_reg[XW-1:0] - 1'b1; ya = i_reg[YW-1:0] - 1'b1;
                ca = j_reg[XW-1:0] - 1'b1; ga = {i_reg[YW-1:0] - 1'b1, j_reg[XW-1:0] - 1'b1}; end
            ST_RD1: begin xa = j_reg[XW-1:0]; ya = i_reg[YW-1:0]; ca = j_reg[XW-1:0];
                ga = {i_reg[YW-1:0] - 1'b1, j_reg[XW-1:0]}; end
            ST_RD2: ga = {i_reg[YW-1:0], j_reg[XW-1:0] - 1'b1};
            ST_RD3: ga = {i_reg[YW-1:0], j_reg[XW-1:0]};
            default: ;
        endcase
    end

    // searching: memory read of idx issued in previous cycle, data now valid
    logic srch_rdv_reg;

    always_comb begin
        st_next = st_reg;
        idx_next = idx_reg;
        lreq = '0;
        unique case (st_reg)
            ST_IDLE: if (accept) begin
                idx_next = '0;
                if (in_mode == MODE_CURVE || in_mode == MODE_SURFACE) st_next = ST_XSRCH;
                else st_next = ST_OUT;
            end
            ST_XSRCH: if (srch_rdv_reg) begin
                if (idx_reg - 5'd1 == nx || !(qx_reg > xbp_rd)) begin
                    idx_next = '0;
                    st_next = (mode_reg == MODE_SURFACE) ? ST_YSRCH : ST_CHECK;
                end else idx_next = idx_reg + 5'd1;
            end else idx_next = idx_reg + 5'd1;
            ST_YSRCH: if (srch_rdv_reg) begin
                if (idx_reg - 5'd1 == ny || !(qy_reg > ybp_rd)) st_next = ST_CHECK;
                else idx_next = idx_reg + 5'd1;
            end else idx_next = idx_reg + 5'd1;
            ST_CHECK: begin
                if (mode_reg == MODE_CURVE && first_reg) st_next = ST_OUT;
                else if (j_reg >= nx || j_reg == 0) st_next = ST_OUT;
                else if (mode_reg == MODE_SURFACE && (i_reg >= ny || i_reg == 0))
                    st_next = ST_OUT;
                else st_next = ST_RD0;
            end
            ST_RD0: st_next = ST_RD1;
            ST_RD1: st_next = ST_RD2;
            ST_RD2: st_next = ST_RD3;
            ST_RD3: st_next = ST_RD4;
            ST_RD4: st_next = ST_L0;
            ST_L0: begin
                lreq.start = 1'b1;
                lreq.p0 = xa_reg; lreq.p1 = xb_reg; lreq.p = qx_reg;
                lreq.v0 = a_reg;  lreq.v1 = b_reg;
                st_next = ST_L0W;
            end
            ST_L0W: if (lrsp.done) st_next = (mode_reg == MODE_CURVE) ? ST_OUT : ST_L1;
            ST_L1: begin
                lreq.start = 1'b1;
                lreq.p0 = xa_reg; lreq.p1 = xb_reg; lreq.p = qx_reg;
                lreq.v0 = c_reg;  lreq.v1 = d_reg;
                st_next = ST_L1W;
            end
            ST_L1W: if (lrsp.done) st_next = ST_L2;
            ST_L2: begin
                lreq.start = 1'b1;
                lreq.p0 = ya_reg; lreq.p1 = yb_reg; lreq.p = qy_reg;
                lreq.v0 = m0_reg; lreq.v1 = m1_reg;
                st_next = ST_L2W;
            end
            ST_L2W: if (lrsp.done) st_next = ST_OUT;
            ST_OUT: if (out_load) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            ovalid_reg <= 1'b0;
            srch_rdv_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            srch_rdv_reg <= (st_next == ST_XSRCH || st_next == ST_YSRCH) &&
                            (st_next == st_reg);
            if (out_load) ovalid_reg <= 1'b1;
            else if (m_tready) ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (accept) begin
            mode_reg <= in_mode;
            qx_reg   <= s_tdata[74:43];
            qy_reg   <= s_tdata[106:75];
            res_reg  <= '0;
            stat_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        // search result: index of rd data is idx_reg-1
        if (st_reg == ST_XSRCH && srch_rdv_reg) begin
            if (idx_reg == 5'd1) first_reg <= (qx_reg == xbp_rd);
            if (idx_reg - 5'd1 == nx) j_reg <= nx;
            else if (!(qx_reg > xbp_rd)) j_reg <= idx_reg - 5'd1;
        end
        if (st_reg == ST_YSRCH && srch_rdv_reg) begin
            if (idx_reg - 5'd1 == ny) i_reg <= ny;
            else if (!(qy_reg > ybp_rd)) i_reg <= idx_reg - 5'd1;
        end
        if (st_reg == ST_CHECK) begin
            if (mode_reg == MODE_CURVE && first_reg) begin
                // read first curve value: j=0 points there via ST_RD path skip
                j_reg <= '0;
            end
        end
        // row 0 of the pair from grid in surface mode, curve table otherwise
        unique case (st_reg)
            ST_RD1: begin
                xa_reg <= xbp_rd; ya_reg <= ybp_rd;
                a_reg <= (mode_reg == MODE_SURFACE) ? grid_rd : crv_rd;
            end
            ST_RD2: begin
                xb_reg <= xbp_rd; yb_reg <= ybp_rd;
                b_reg <= (mode_reg == MODE_SURFACE) ? grid_rd : crv_rd;
            end
            ST_RD3: c_reg <= grid_rd;
            ST_RD4: d_reg <= grid_rd;
            default: ;
        endcase
        if (st_reg == ST_L0W && lrsp.done) m0_reg <= lrsp.value;
        if (st_reg == ST_L1W && lrsp.done) m1_reg <= lrsp.value;
        if (st_reg == ST_CHECK) begin
            if (mode_reg == MODE_CURVE && first_reg) ;
            else if (j_reg >= nx || j_reg == 0 ||
                     (mode_reg == MODE_SURFACE && (i_reg >= ny || i_reg == 0)))
                stat_reg <= 1'b1;
        end
        if (st_reg == ST_L0W && lrsp.done && mode_reg == MODE_CURVE) res_reg <= lrsp.value;
        if (st_reg == ST_L2W && lrsp.done) res_reg <= lrsp.value;
        // exact first hit: curve value 0 is on the read port (ca = j = 0)
        if (out_load) begin
            ores_reg  <= (mode_reg == MODE_CURVE && first_reg) ? crv_rd : res_reg;
            ostat_reg <= stat_reg;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {7'd0, ostat_reg, ores_reg};

endmodule

`default_nettype wire
